>>> design/rmst_pkg.sv
// Shared definitions for the range-minimum segment tree: sizes, request and
// result structs, command codes and the saturation helpers.
// No dependencies.
`default_nettype none

package rmst_pkg;

  // Tree geometry and stored word size
  localparam int Leaves    = 1024;
  localparam int ValueBits = 32;
  localparam int LeafBits  = $clog2(Leaves);
  localparam int NodeBits  = LeafBits + 1;
  localparam int NodeCount = 2 * Leaves;
  localparam int WalkBits  = NodeBits + 1;

  // Fixed field widths of the request and result
  localparam int IndexBits = 10;
  localparam int DataBits  = 32;

  localparam logic signed [63:0] ValMax64 = (64'sd1 <<< (ValueBits - 1)) - 64'sd1;
  localparam logic signed [63:0] ValMin64 = -ValMax64 - 64'sd1;
  localparam logic signed [63:0] OutMax64 = 64'sd2147483647;
  localparam logic signed [63:0] OutMin64 = -64'sd2147483648;
  localparam logic signed [ValueBits-1:0] NodeTop = ValMax64[ValueBits-1:0];

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdQuery = 1'b1
  } rmst_cmd_e;

  typedef struct packed {
    rmst_cmd_e                   cmd;
    logic        [IndexBits-1:0] write_index;
    logic signed [DataBits-1:0]  write_value;
    logic        [IndexBits-1:0] range_low;
    logic        [IndexBits-1:0] range_high;
  } rmst_req_t;

  typedef struct packed {
    logic signed [DataBits-1:0] minimum;
    logic                       range_error;
  } rmst_rsp_t;

  // Clamp an incoming value to the stored range
  function automatic logic signed [ValueBits-1:0] sat_in(input logic signed [DataBits-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > ValMax64) begin
      w = ValMax64;
    end else if (w < ValMin64) begin
      w = ValMin64;
    end
    return w[ValueBits-1:0];
  endfunction

  // Clamp a stored value to the result field
  function automatic logic signed [DataBits-1:0] sat_out(input logic signed [ValueBits-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > OutMax64) begin
      w = OutMax64;
    end else if (w < OutMin64) begin
      w = OutMin64;
    end
    return w[DataBits-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/rmst_min_unit.sv
// Shared signed minimum unit of the segment tree walker.
// Depends on rmst_pkg.
`default_nettype none

module rmst_min_unit
  import rmst_pkg::*;
(
  input  logic signed [ValueBits-1:0] op_a_i,
  input  logic signed [ValueBits-1:0] op_b_i,
  output logic signed [ValueBits-1:0] min_o
);

  assign min_o = (op_b_i < op_a_i) ? op_b_i : op_a_i;

endmodule

`default_nettype wire

>>> design/rmst_seq.sv
// Sequencer of the segment tree: node memory, clearing sweep, leaf-to-root
// update walk and bottom-up query walk around one shared minimum unit.
// Depends on rmst_pkg and rmst_min_unit.
`default_nettype none

module rmst_seq
  import rmst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  rmst_req_t req_i,
  output logic      res_valid_o,
  input  logic      res_stall_i,
  output rmst_rsp_t res_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StQryA  = 3'd3;
  localparam logic [2:0] StQryB  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;

  // node memory
  logic        [ValueBits-1:0] mem_q [NodeCount];
  logic signed [ValueBits-1:0] rdata_q;
  logic                        we;
  logic        [NodeBits-1:0]  waddr;
  logic        [NodeBits-1:0]  raddr;
  logic signed [ValueBits-1:0] wdata;

  logic [NodeBits-1:0] clr_q, clr_d;
  logic                pend_q, pend_d;
  logic                err_q, err_d;

  logic        [NodeBits-1:0]  node_q, node_d;
  logic signed [ValueBits-1:0] cur_q, cur_d;
  logic signed [ValueBits-1:0] best_q, best_d;
  logic        [WalkBits-1:0]  a_q, a_d;
  logic        [WalkBits-1:0]  b_q, b_d;

  logic signed [ValueBits-1:0] op_a;
  logic signed [ValueBits-1:0] min_val;
  logic        [NodeBits-1:0]  parent;
  logic        [NodeBits-1:0]  leaf;
  logic        [LeafBits-1:0]  lo;
  logic        [LeafBits-1:0]  hi;
  logic        [WalkBits-1:0]  b_dec;
  logic                        accept;

  assign accept = req_valid_i && (state_q == StIdle);
  assign req_stall_o = (state_q != StIdle);

  assign lo     = LeafBits'(req_i.range_low);
  assign hi     = LeafBits'(req_i.range_high);
  assign leaf   = {1'b1, LeafBits'(req_i.write_index)};
  assign parent = node_q >> 1;
  assign b_dec  = b_q - WalkBits'(1);

  assign op_a = (state_q == StWalk) ? cur_q : best_q;

  rmst_min_unit u_min (
    .op_a_i(op_a),
    .op_b_i(rdata_q),
    .min_o (min_val)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    pend_d  = 1'b0;
    err_d   = err_q;
    node_d  = node_q;
    cur_d   = cur_q;
    best_d  = pend_q ? min_val : best_q;
    a_d     = a_q;
    b_d     = b_q;
    we      = 1'b0;
    waddr   = node_q;
    wdata   = cur_q;
    raddr   = '0;
    res_valid_o = 1'b0;
    res_o.minimum     = err_q ? '0 : sat_out(best_q);
    res_o.range_error = err_q;

    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = NodeTop;
        clr_d = clr_q + NodeBits'(1);
        if (clr_q == {NodeBits{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          if (req_i.cmd == CmdWrite) begin
            // store the leaf, fetch its sibling
            we      = 1'b1;
            waddr   = leaf;
            wdata   = sat_in(req_i.write_value);
            raddr   = leaf ^ NodeBits'(1);
            node_d  = leaf;
            cur_d   = sat_in(req_i.write_value);
            state_d = StWalk;
          end else if (lo > hi) begin
            err_d   = 1'b1;
            state_d = StDone;
          end else begin
            err_d   = 1'b0;
            best_d  = NodeTop;
            a_d     = WalkBits'(Leaves) + WalkBits'(lo);
            b_d     = WalkBits'(Leaves) + WalkBits'(hi) + WalkBits'(1);
            state_d = StQryA;
          end
        end
      end
      StWalk: begin
        // parent takes min of the known child and the fetched sibling
        we     = 1'b1;
        waddr  = parent;
        wdata  = min_val;
        cur_d  = min_val;
        node_d = parent;
        raddr  = parent ^ NodeBits'(1);
        if (parent == NodeBits'(1)) begin
          state_d = StIdle;
        end
      end
      StQryA: begin
        if (a_q < b_q) begin
          if (a_q[0]) begin
            raddr  = a_q[NodeBits-1:0];
            pend_d = 1'b1;
            a_d    = a_q + WalkBits'(1);
          end
          state_d = StQryB;
        end else begin
          state_d = StDone;
        end
      end
      StQryB: begin
        if (b_q[0]) begin
          raddr  = b_dec[NodeBits-1:0];
          pend_d = 1'b1;
          b_d    = b_dec >> 1;
        end else begin
          b_d = b_q >> 1;
        end
        a_d     = a_q >> 1;
        state_d = StQryA;
      end
      StDone: begin
        res_valid_o = 1'b1;
        if (!res_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    a_q    <= a_d;
    b_q    <= b_d;
  end

endmodule

`default_nettype wire

>>> design/range_minimum_segment_tree.sv
// Top level of the range-minimum segment tree: request port, tree sequencer
// and the result output register.
// Depends on rmst_pkg and rmst_seq.
`default_nettype none

//  channel   direction  handshake                 payload
//  request   in         in_valid_i / in_stall_o   in_req_i  (rmst_req_t)
//  result    out        out_valid_o / out_stall_i out_rsp_o (rmst_rsp_t)
//
// A write stores the leaf, then rewrites each ancestor up to the root from
// one sibling read per cycle. A query walks the tree bottom-up with one
// step on the low bound and one on the high bound per tree level; a reversed
// range goes straight to a result flagged as a range error. The single
// read port of the node memory paces both walks. Writes give no result.
// After reset the node memory is swept to the largest value, one node per
// cycle; requests stall meanwhile. A held result in the output register
// does not block the next request; only a second finished query waits for
// the register to drain.

module range_minimum_segment_tree
  import rmst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rmst_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rmst_rsp_t out_rsp_o
);

  logic      res_valid;
  logic      res_stall;
  rmst_rsp_t res;

  logic      out_valid_q, out_valid_d;
  rmst_rsp_t out_q;
  logic      load;

  rmst_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_stall_o(in_stall_o),
    .req_i      (in_req_i),
    .res_valid_o(res_valid),
    .res_stall_i(res_stall),
    .res_o      (res)
  );

  // take a finished result when the register is empty or draining
  assign load        = res_valid && (!out_valid_q || !out_stall_i);
  assign res_stall   = !load;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire
